/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, pre, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, pre, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, pre, cons, msg)
`define ASSERT_NEXT(lbl, pre, cons, msg)
`endif
`endif

/* src/bitu_pkg.sv */
// Types, constants and helpers of the broadcast index translate unit.
`default_nettype none
package bitu_pkg;
  localparam int IdxW     = 16;
  localparam int DivBits  = 4;
  localparam int DivSteps = IdxW / DivBits;

  typedef enum logic [3:0] {
    REG_A_SHAPE   = 4'd0,
    REG_A_STRIDE  = 4'd1,
    REG_B_SHAPE   = 4'd2,
    REG_B_STRIDE  = 4'd3,
    REG_OUT_SHAPE = 4'd4,
    REG_A_RANK    = 4'd5,
    REG_B_RANK    = 4'd6,
    REG_OUT_RANK  = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [IdxW-1:0] rem;
    logic [IdxW-1:0] num;
    logic [IdxW-1:0] acc_a;
    logic [IdxW-1:0] acc_b;
  } stage_t;

  typedef struct packed {
    logic [IdxW-1:0] size;
    logic            a_en;
    logic [IdxW-1:0] a_stride;
    logic            b_en;
    logic [IdxW-1:0] b_stride;
  } dim_cfg_t;

  function automatic logic [IdxW-1:0] lane(input logic [63:0] p, input logic [1:0] d);
    lane = p[d*IdxW +: IdxW];
  endfunction
endpackage
`default_nettype wire

/* src/bitu_divstep.sv */
// One registered stage of the restoring divider, DivBits quotient bits per stage.
`default_nettype none
module bitu_divstep import bitu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic [IdxW-1:0] size_i,
  input  wire logic      valid_i,
  input  wire stage_t    data_i,
  input  wire logic      next_load_i,
  output logic           load_o,
  output logic           valid_o,
  output stage_t         data_o
);
  logic   valid_q;
  stage_t data_q, data_d;

  always_comb begin
    logic [IdxW:0]   t;
    logic [IdxW-1:0] r;
    logic [IdxW-1:0] n;
    r = data_i.rem;
    n = data_i.num;
    t = '0;
    for (int i = 0; i < DivBits; i++) begin
      t = {r, n[IdxW-1]};
      n = {n[IdxW-2:0], 1'b0};
      if (t >= {1'b0, size_i}) begin
        t    = t - {1'b0, size_i};
        n[0] = 1'b1;
      end
      r = t[IdxW-1:0];
    end
    data_d     = data_i;
    data_d.rem = r;
    data_d.num = n;
  end

  assign load_o = !valid_q || next_load_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

/* src/bitu_mac.sv */
// Registered stage adding coordinate times stride to each enabled source index.
`default_nettype none
module bitu_mac import bitu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire dim_cfg_t  cfg_i,
  input  wire logic      valid_i,
  input  wire stage_t    data_i,
  input  wire logic      next_load_i,
  output logic           load_o,
  output logic           valid_o,
  output stage_t         data_o
);
  logic   valid_q;
  stage_t data_q, data_d;

  always_comb begin
    logic [2*IdxW-1:0] pa;
    logic [2*IdxW-1:0] pb;
    pa = data_i.rem * cfg_i.a_stride;
    pb = data_i.rem * cfg_i.b_stride;
    data_d     = data_i;
    data_d.rem = '0;  // quotient in num is the next dimension's dividend
    if (cfg_i.a_en) begin
      data_d.acc_a = data_i.acc_a + pa[IdxW-1:0];
    end
    if (cfg_i.b_en) begin
      data_d.acc_b = data_i.acc_b + pb[IdxW-1:0];
    end
  end

  assign load_o = !valid_q || next_load_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

/* src/bitu_dim.sv */
// One output dimension: divider stages followed by the accumulate stage.
`default_nettype none
module bitu_dim import bitu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire dim_cfg_t  cfg_i,
  input  wire logic      valid_i,
  input  wire stage_t    data_i,
  input  wire logic      next_load_i,
  output logic           load_o,
  output logic           valid_o,
  output stage_t         data_o
);
  logic   v    [DivSteps+1];
  stage_t d    [DivSteps+1];
  logic   ld   [DivSteps+1];

  assign v[0] = valid_i;
  assign d[0] = data_i;

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    bitu_divstep u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .size_i     (cfg_i.size),
      .valid_i    (v[s]),
      .data_i     (d[s]),
      .next_load_i(ld[s+1]),
      .load_o     (ld[s]),
      .valid_o    (v[s+1]),
      .data_o     (d[s+1])
    );
  end

  bitu_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .valid_i    (v[DivSteps]),
    .data_i     (d[DivSteps]),
    .next_load_i(next_load_i),
    .load_o     (ld[DivSteps]),
    .valid_o    (valid_o),
    .data_o     (data_o)
  );

  assign load_o = ld[0];
endmodule
`default_nettype wire

/* src/broadcast_index_translate_unit.sv */
// Top level: broadcast output index to source A and B data indices.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  out_index_i
// out       output     out_valid_o/out_stall_i a_index_o, b_index_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while out_stall_i is low; each dimension
// is the divider (four 4-bit stages) plus one multiply-accumulate stage.
// Each stage holds its own valid bit; bubbles collapse under out_stall_i, so
// new transactions are taken until every stage is full.
// Reset clears valid bits and loads the register defaults; cfg is always ready.
`default_nettype none
module broadcast_index_translate_unit import bitu_pkg::*; #(
  parameter int MAX_DIMS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] out_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      a_index_o,
  output logic [15:0]      b_index_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
`include "assert_macros.svh"

  localparam logic [2:0] MaxRank = 3'(MAX_DIMS);

  logic [63:0] a_shape_q, a_stride_q, b_shape_q, b_stride_q, out_shape_q;
  logic [2:0]  a_rank_q, b_rank_q, out_rank_q;
  logic [2:0]  ar, br, orr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_shape_q   <= 64'h0001_0001_0001_0001;
      a_stride_q  <= '0;
      b_shape_q   <= 64'h0001_0001_0001_0001;
      b_stride_q  <= '0;
      out_shape_q <= 64'h0001_0001_0001_0001;
      a_rank_q    <= '0;
      b_rank_q    <= '0;
      out_rank_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_A_SHAPE:   a_shape_q   <= cfg_data_i;
        REG_A_STRIDE:  a_stride_q  <= cfg_data_i;
        REG_B_SHAPE:   b_shape_q   <= cfg_data_i;
        REG_B_STRIDE:  b_stride_q  <= cfg_data_i;
        REG_OUT_SHAPE: out_shape_q <= cfg_data_i;
        REG_A_RANK:    a_rank_q    <= cfg_data_i[2:0];
        REG_B_RANK:    b_rank_q    <= cfg_data_i[2:0];
        REG_OUT_RANK:  out_rank_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign ar  = (a_rank_q   > MaxRank) ? MaxRank : a_rank_q;
  assign br  = (b_rank_q   > MaxRank) ? MaxRank : b_rank_q;
  assign orr = (out_rank_q > MaxRank) ? MaxRank : out_rank_q;

  logic     v   [MAX_DIMS+1];
  stage_t   d   [MAX_DIMS+1];
  logic     ld  [MAX_DIMS+1];
  dim_cfg_t dcfg[MAX_DIMS];

  always_comb begin
    d[0]       = '0;
    d[0].num   = out_index_i;
  end
  assign v[0] = in_valid_i;
  assign ld[MAX_DIMS] = !out_stall_i;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
    logic [2:0]  od, ad, bd;
    logic [15:0] osz;
    logic        act;
    // Dimensions aligned from the right: step k visits the k-th from last.
    assign od  = orr - 3'd1 - 3'(k);
    assign ad  = ar  - 3'd1 - 3'(k);
    assign bd  = br  - 3'd1 - 3'(k);
    assign act = 3'(k) < orr;
    assign osz = lane(out_shape_q, od[1:0]);
    always_comb begin
      dcfg[k].size     = (osz == 16'd0) ? 16'd1 : osz;
      dcfg[k].a_en     = act && (3'(k) < ar) && (lane(a_shape_q, ad[1:0]) > 16'd1);
      dcfg[k].a_stride = lane(a_stride_q, ad[1:0]);
      dcfg[k].b_en     = act && (3'(k) < br) && (lane(b_shape_q, bd[1:0]) > 16'd1);
      dcfg[k].b_stride = lane(b_stride_q, bd[1:0]);
    end

    bitu_dim u_dim (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_i      (dcfg[k]),
      .valid_i    (v[k]),
      .data_i     (d[k]),
      .next_load_i(ld[k+1]),
      .load_o     (ld[k]),
      .valid_o    (v[k+1]),
      .data_o     (d[k+1])
    );
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = v[MAX_DIMS];
  assign a_index_o   = d[MAX_DIMS].acc_a;
  assign b_index_o   = d[MAX_DIMS].acc_b;

  `ASSERT_IMPL(a_rank_zero, out_valid_o && (a_rank_q == 3'd0), a_index_o == 16'd0, "a_index nonzero with rank 0")
  `ASSERT_IMPL(out_rank_zero, out_valid_o && (out_rank_q == 3'd0), (a_index_o == 16'd0) && (b_index_o == 16'd0), "index nonzero with output rank 0")
  `ASSERT_IMPL(stall_full, in_stall_o, out_valid_o && out_stall_i, "input stalled with room in the pipeline")
endmodule
`default_nettype wire

/* bench/tb_broadcast_index_translate_unit.sv */
// Testbench of the broadcast index translate unit: random and directed index checks.
`timescale 1ns / 1ps
`default_nettype none
module tb_broadcast_index_translate_unit;
  import bitu_pkg::*;

  localparam int NDIM      = 4;
  localparam int LATENCY   = NDIM * 5;
  localparam int WDOG_MAX  = 20000;

  typedef struct packed {
    logic [15:0] a_idx;
    logic [15:0] b_idx;
  } idx_pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] out_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] a_index_o;
  logic [15:0] b_index_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  // shadow copy of the unit's registers
  logic [63:0] m_a_shape, m_a_stride, m_b_shape, m_b_stride, m_out_shape;
  logic [2:0]  m_a_rank, m_b_rank, m_out_rank;

  idx_pair_t   pending_idx[$];
  int          n_errors = 0;
  int          idle_cycles = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;

  broadcast_index_translate_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_index_i,
    .out_valid_o, .out_stall_i, .a_index_o, .b_index_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] dim_size(input logic [63:0] p, input int d);
    return p[d*16 +: 16];
  endfunction

  function automatic int clamp_rank(input logic [2:0] r);
    return (r > NDIM) ? NDIM : int'(r);
  endfunction

  function automatic idx_pair_t translate_index(input logic [15:0] flat);
    idx_pair_t res;
    int unsigned rem, sz, coord;
    int ar, br, orr, od, ad, bd;
    logic [15:0] acc_a, acc_b;
    rem = flat;
    ar = clamp_rank(m_a_rank);
    br = clamp_rank(m_b_rank);
    orr = clamp_rank(m_out_rank);
    acc_a = '0;
    acc_b = '0;
    for (int k = 0; k < orr; k++) begin
      od = orr - 1 - k;
      sz = dim_size(m_out_shape, od);
      if (sz == 0) sz = 1;
      coord = rem % sz;
      rem = rem / sz;
      if (k < ar) begin
        ad = ar - 1 - k;
        if (dim_size(m_a_shape, ad) > 1)
          acc_a = acc_a + 16'(coord * dim_size(m_a_stride, ad));
      end
      if (k < br) begin
        bd = br - 1 - k;
        if (dim_size(m_b_shape, bd) > 1)
          acc_b = acc_b + 16'(coord * dim_size(m_b_stride, bd));
      end
    end
    res.a_idx = acc_a;
    res.b_idx = acc_b;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  task automatic reset_shadow();
    m_a_shape = 64'h0001_0001_0001_0001;
    m_a_stride = '0;
    m_b_shape = 64'h0001_0001_0001_0001;
    m_b_stride = '0;
    m_out_shape = 64'h0001_0001_0001_0001;
    m_a_rank = '0;
    m_b_rank = '0;
    m_out_rank = '0;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_A_SHAPE:   m_a_shape = val;
      REG_A_STRIDE:  m_a_stride = val;
      REG_B_SHAPE:   m_b_shape = val;
      REG_B_STRIDE:  m_b_stride = val;
      REG_OUT_SHAPE: m_out_shape = val;
      REG_A_RANK:    m_a_rank = val[2:0];
      REG_B_RANK:    m_b_rank = val[2:0];
      REG_OUT_RANK:  m_out_rank = val[2:0];
      default: ;
    endcase
  endtask

  // an index outside the register list must leave every register alone
  task automatic write_unknown_reg(input logic [3:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_index(input logic [15:0] flat);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    out_index_i <= flat;
    do @(posedge clk_i); while (in_stall_o);
    pending_idx.push_back(translate_index(flat));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_idx.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic set_shape(input logic [63:0] as, input logic [63:0] ast,
                           input logic [63:0] bs, input logic [63:0] bst,
                           input logic [63:0] os, input logic [2:0] ar,
                           input logic [2:0] br, input logic [2:0] orr);
    write_reg(REG_A_SHAPE, as);
    write_reg(REG_A_STRIDE, ast);
    write_reg(REG_B_SHAPE, bs);
    write_reg(REG_B_STRIDE, bst);
    write_reg(REG_OUT_SHAPE, os);
    write_reg(REG_A_RANK, 64'(ar));
    write_reg(REG_B_RANK, 64'(br));
    write_reg(REG_OUT_RANK, 64'(orr));
  endtask

  function automatic logic [63:0] rand_shape();
    logic [63:0] p;
    for (int d = 0; d < NDIM; d++) begin
      case ($urandom_range(5))
        0: p[d*16 +: 16] = 16'd0;
        1: p[d*16 +: 16] = 16'd1;
        2: p[d*16 +: 16] = 16'hFFFF;
        3: p[d*16 +: 16] = 16'($urandom);
        default: p[d*16 +: 16] = 16'($urandom_range(2, 9));
      endcase
    end
    return p;
  endfunction

  function automatic logic [63:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_defaults();
    send_index(16'h0000);
    send_index(16'hFFFF);
    send_index(16'h1234);
    drain();
  endtask

  task automatic test_directed_shapes();
    // a [3,4] against out [2,3,4], b [2,1,1]: plain broadcast
    set_shape(64'h0000_0000_0004_0003, 64'h0000_0000_0001_0004,
              64'h0000_0001_0001_0002, 64'h0000_0001_0001_000C,
              64'h0000_0004_0003_0002, 3'd2, 3'd3, 3'd3);
    for (int i = 0; i < 6; i++) send_index(16'(i * 5));
    send_index(16'hFFFF);
    drain();
    // zero output sizes, rank above the limit, strides at their extremes
    set_shape(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'h0002_0000_0003_0001, 64'hFFFF_0001_8000_0007,
              64'h0000_0007_0000_FFFF, 3'd7, 3'd5, 3'd7);
    send_index(16'h0000);
    send_index(16'hFFFF);
    send_index(16'h8001);
    send_index(16'h7FFE);
    drain();
    // source rank above output rank; output rank zero
    set_shape(64'h0005_0004_0003_0002, 64'h0100_0010_0004_0001,
              64'h0005_0004_0003_0002, 64'h0001_0002_0003_0004,
              64'h0000_0000_0005_0004, 3'd4, 3'd4, 3'd1);
    send_index(16'd3);
    send_index(16'd99);
    drain();
    write_reg(REG_OUT_RANK, 64'd0);
    send_index(16'hABCD);
    drain();
    write_unknown_reg(4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    write_unknown_reg(4'd15, 64'h0);
    send_index(16'h5555);
    drain();
  endtask

  task automatic test_random_items(input int n_items, input int gap, input int stall);
    send_gap_pct = gap;
    recv_stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        drain();
        set_shape(rand_shape(), rand_wide(), rand_shape(), rand_wide(),
                  rand_shape(), 3'($urandom), 3'($urandom), 3'($urandom_range(1, 7)));
      end
      case ($urandom_range(3))
        0: send_index(16'($urandom_range(0, 63)));
        default: send_index(16'($urandom));
      endcase
    end
    drain();
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // result check
  always @(posedge clk_i) begin
    idx_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_idx.size() == 0) begin
        $display("unexpected transaction a=%h b=%h at %0t", a_index_o, b_index_o, $realtime);
        n_errors++;
      end else begin
        want = pending_idx.pop_front();
        if (a_index_o !== want.a_idx) report_mismatch("a_index", a_index_o, want.a_idx);
        if (b_index_o !== want.b_idx) report_mismatch("b_index", b_index_o, want.b_idx);
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_shapes();
    test_random_items(280, 8, 50);
    test_random_items(280, 50, 8);
    test_random_items(280, 0, 0);
    if (n_errors == 0 && pending_idx.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
